/* design/cpm_pkg.sv */
// Shared types and constants for the CPU priority map.
// Used by cpm_datapath, cpm_ctrl and cpu_priority_map_top; no dependencies.
package cpm_pkg;

   localparam int NUM_CPUS   = 32;
   localparam int NUM_LEVELS = 64;
   localparam int LEVEL_TOP  = ((NUM_LEVELS < 64) ? NUM_LEVELS : 64) - 1;
   localparam int CPU_W      = $clog2(NUM_CPUS);
   localparam int LVL_W      = 7;
   localparam int LEVEL_W    = 6;
   localparam int PRIO_W     = 8;
   localparam int MAXRT_W    = 6;
   localparam int LANES      = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [LVL_W-1:0] NO_LEVEL = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_PRIO    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVALID_PRIO = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RT_PRIO  = 2'd2;

   typedef enum logic {
      REQ_SET  = 1'b0,
      REQ_FIND = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic emit;
   } cpm_cmd_type;

   typedef struct packed {
      logic is_find;
      logic scan_done;
      logic slot_free;
   } cpm_sts_type;

endpackage

/* design/cpm_datapath.sv */
// Datapath of the CPU priority map: configuration, per-CPU levels, level scan, result beat.
// Depends on cpm_pkg; driven by cpm_ctrl through cpm_cmd_type.
module cpm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  cpm_pkg::cpm_cmd_type                cmd,
   output cpm_pkg::cpm_sts_type                sts,
   input  logic                                req_type,
   input  logic [cpm_pkg::CPU_W-1:0]           req_cpu_index,
   input  logic [cpm_pkg::PRIO_W-1:0]          req_priority_req,
   input  logic [cpm_pkg::NUM_CPUS-1:0]        req_affinity_mask,
   input  logic                                csr_write_en,
   input  logic [cpm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cpm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [cpm_pkg::NUM_CPUS-1:0]        rsp_candidate_mask,
   output logic [cpm_pkg::LEVEL_W-1:0]         rsp_found_level
);
   import cpm_pkg::*;

   logic [PRIO_W-1:0]  idle_prio_ff, idle_prio_in;
   logic [PRIO_W-1:0]  invalid_prio_ff, invalid_prio_in;
   logic [MAXRT_W-1:0] max_rt_ff, max_rt_in;

   logic [LVL_W-1:0] cpu_levels_ff [NUM_CPUS];
   logic [LVL_W-1:0] cpu_levels_in [NUM_CPUS];

   req_kind_type         kind_ff, kind_in;
   logic [CPU_W-1:0]     cpu_ff, cpu_in;
   logic [LVL_W-1:0]     lv_ff, lv_in;
   logic [NUM_CPUS-1:0]  aff_ff, aff_in;
   logic [LVL_W-1:0]     base_ff, base_in;
   logic                 res_found_ff, res_found_in;
   logic [NUM_CPUS-1:0]  res_mask_ff, res_mask_in;
   logic [LEVEL_W-1:0]   res_level_ff, res_level_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [NUM_CPUS-1:0]  rsp_mask_ff, rsp_mask_in;
   logic [LEVEL_W-1:0]   rsp_level_ff, rsp_level_in;

   logic [LVL_W-1:0]     limit;
   logic [LVL_W:0]       next_base;
   logic [LVL_W-1:0]     lane_level [LANES];
   logic [NUM_CPUS-1:0]  lane_hit [LANES];
   logic [LANES-1:0]     lane_any;
   logic                 hit_any;
   logic [NUM_CPUS-1:0]  hit_mask;
   logic [LEVEL_W-1:0]   hit_level;

   function automatic logic [LVL_W-1:0] map_level(
      input logic [PRIO_W-1:0]  p,
      input logic [PRIO_W-1:0]  idle_p,
      input logic [PRIO_W-1:0]  invalid_p,
      input logic [MAXRT_W-1:0] max_rt
   );
      logic [PRIO_W-1:0] lv;
      logic [PRIO_W-1:0] max_ext;
      max_ext = PRIO_W'(max_rt);
      if (p == idle_p) begin
         return '0;
      end
      if (p == invalid_p) begin
         return NO_LEVEL;
      end
      if (p > max_ext) begin
         lv = PRIO_W'(1);
      end else begin
         lv = max_ext - p + PRIO_W'(2);
      end
      if (lv > PRIO_W'(LEVEL_TOP)) begin
         lv = PRIO_W'(LEVEL_TOP);
      end
      return lv[LVL_W-1:0];
   endfunction

   // Configuration registers.
   always_comb begin
      idle_prio_in    = idle_prio_ff;
      invalid_prio_in = invalid_prio_ff;
      max_rt_in       = max_rt_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_IDLE_PRIO:    idle_prio_in    = csr_wdata;
            CSR_INVALID_PRIO: invalid_prio_in = csr_wdata;
            CSR_MAX_RT_PRIO:  max_rt_in       = csr_wdata[MAXRT_W-1:0];
            default: ;
         endcase
      end
   end

   // Four levels are compared against every CPU level in each scan step.
   always_comb begin
      limit     = (lv_ff == NO_LEVEL) ? '0 : lv_ff;
      next_base = {1'b0, base_ff} + (LVL_W+1)'(LANES);
      for (int k = 0; k < LANES; k++) begin
         lane_level[k] = base_ff + LVL_W'(k);
         for (int c = 0; c < NUM_CPUS; c++) begin
            lane_hit[k][c] = aff_ff[c] && (cpu_levels_ff[c] == lane_level[k]);
         end
         lane_any[k] = (lane_level[k] < limit) && (|lane_hit[k]);
      end
      hit_any   = 1'b0;
      hit_mask  = '0;
      hit_level = '0;
      for (int k = LANES - 1; k >= 0; k--) begin
         if (lane_any[k]) begin
            hit_any   = 1'b1;
            hit_mask  = lane_hit[k];
            hit_level = lane_level[k][LEVEL_W-1:0];
         end
      end
   end

   always_comb begin
      sts.is_find   = (kind_ff == REQ_FIND);
      sts.scan_done = hit_any || (next_base >= {1'b0, limit});
      sts.slot_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      kind_in      = kind_ff;
      cpu_in       = cpu_ff;
      lv_in        = lv_ff;
      aff_in       = aff_ff;
      base_in      = base_ff;
      res_found_in = res_found_ff;
      res_mask_in  = res_mask_ff;
      res_level_in = res_level_ff;
      rsp_found_in = rsp_found_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_level_in = rsp_level_ff;
      cpu_levels_in = cpu_levels_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load) begin
         kind_in      = req_kind_type'(req_type);
         cpu_in       = req_cpu_index;
         lv_in        = map_level(req_priority_req, idle_prio_ff, invalid_prio_ff, max_rt_ff);
         aff_in       = req_affinity_mask;
         base_in      = '0;
         res_found_in = 1'b0;
         res_mask_in  = '0;
         res_level_in = '0;
      end
      if (cmd.step) begin
         base_in = next_base[LVL_W-1:0];
         if (hit_any) begin
            res_found_in = 1'b1;
            res_mask_in  = hit_mask;
            res_level_in = hit_level;
         end
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = res_found_ff;
         rsp_mask_in  = res_mask_ff;
         rsp_level_in = res_level_ff;
         if (kind_ff == REQ_SET) begin
            cpu_levels_in[cpu_ff] = lv_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_prio_ff    <= PRIO_W'(255);
         invalid_prio_ff <= PRIO_W'(254);
         max_rt_ff       <= MAXRT_W'(47);
         rsp_valid_ff    <= 1'b0;
         for (int c = 0; c < NUM_CPUS; c++) begin
            cpu_levels_ff[c] <= NO_LEVEL;
         end
      end else begin
         idle_prio_ff    <= idle_prio_in;
         invalid_prio_ff <= invalid_prio_in;
         max_rt_ff       <= max_rt_in;
         rsp_valid_ff    <= rsp_valid_in;
         cpu_levels_ff   <= cpu_levels_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      cpu_ff       <= cpu_in;
      lv_ff        <= lv_in;
      aff_ff       <= aff_in;
      base_ff      <= base_in;
      res_found_ff <= res_found_in;
      res_mask_ff  <= res_mask_in;
      res_level_ff <= res_level_in;
      rsp_found_ff <= rsp_found_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_level_ff <= rsp_level_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_candidate_mask = rsp_mask_ff;
   assign rsp_found_level    = rsp_level_ff;

   a_hit_below_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.step && hit_any |-> ({1'b0, hit_level} < limit))
      else $error("scan hit at a level not below the thread level");

   a_set_writes_level: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && (kind_ff == REQ_SET) |=> cpu_levels_ff[$past(cpu_ff)] == $past(lv_ff))
      else $error("set beat did not update the CPU level");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> (rsp_mask_ff == '0) && (rsp_level_ff == '0))
      else $error("result without a match carries a nonzero mask or level");

endmodule

/* design/cpm_ctrl.sv */
// Controller state machine of the CPU priority map.
// Depends on cpm_pkg; commands cpm_datapath and reads its status.
module cpm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output cpm_pkg::cpm_cmd_type  cmd,
   input  cpm_pkg::cpm_sts_type  sts
);
   import cpm_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!sts.is_find || sts.scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SCAN: begin
            cmd.step = sts.is_find;
         end
         ST_EMIT: begin
            cmd.emit = sts.slot_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_SCAN)
      else $error("accepted beat did not start processing");

   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.slot_free)
      else $error("result emitted while the output register is occupied");

   a_find_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && sts.is_find |-> cmd.step)
      else $error("find request stalled in the scan state");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.emit}))
      else $error("more than one datapath command at once");

endmodule

/* design/cpu_priority_map_top.sv */
// CPU priority map top level: a set passes from the idle state through the scan and emit states
// without stepping; a find steps through the scan state until a hit or its thread level is reached.
// A new request is taken only once the previous result has been emitted to the output register.
// The scan width of four levels per cycle sets the find time.
// Synchronous active-high reset puts every CPU at no level and loads idle 255,
// invalid 254 and highest realtime 47.
module cpu_priority_map_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [cpm_pkg::CPU_W-1:0]           req_cpu_index,
   input  logic [cpm_pkg::PRIO_W-1:0]          req_priority_req,
   input  logic [cpm_pkg::NUM_CPUS-1:0]        req_affinity_mask,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [cpm_pkg::NUM_CPUS-1:0]        rsp_candidate_mask,
   output logic [cpm_pkg::LEVEL_W-1:0]         rsp_found_level,
   input  logic                                csr_write_en,
   input  logic [cpm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cpm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import cpm_pkg::*;

   cpm_cmd_type cmd;
   cpm_sts_type sts;

   cpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   cpm_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_type           (req_type),
      .req_cpu_index      (req_cpu_index),
      .req_priority_req   (req_priority_req),
      .req_affinity_mask  (req_affinity_mask),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found          (rsp_found),
      .rsp_candidate_mask (rsp_candidate_mask),
      .rsp_found_level    (rsp_found_level)
   );

endmodule

/* bench/cpu_priority_map_top_tb.sv */
// Self-checking testbench for cpu_priority_map_top: set and find beats with random idling,
// checked against an in-bench priority map. Depends on cpm_pkg and the top-level RTL.
module cpu_priority_map_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cpm_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 24;
   localparam int LONG_HOLD     = 400;
   localparam int GROUP_ITEMS   = 254;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      req_kind_type          kind;
      logic [CPU_W-1:0]      cpu;
      logic [PRIO_W-1:0]     prio;
      logic [NUM_CPUS-1:0]   affinity;
   } map_request_type;

   typedef struct packed {
      logic                  found;
      logic [NUM_CPUS-1:0]   candidates;
      logic [LEVEL_W-1:0]    level;
   } map_answer_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_type = 1'b0;
   logic [CPU_W-1:0]      req_cpu_index = '0;
   logic [PRIO_W-1:0]     req_priority_req = '0;
   logic [NUM_CPUS-1:0]   req_affinity_mask = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_found;
   logic [NUM_CPUS-1:0]   rsp_candidate_mask;
   logic [LEVEL_W-1:0]    rsp_found_level;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [PRIO_W-1:0]     idle_prio_cfg = 8'd255;
   logic [PRIO_W-1:0]     invalid_prio_cfg = 8'd254;
   logic [MAXRT_W-1:0]    max_rt_cfg = 6'd47;
   logic [NUM_CPUS-1:0]   level_mask [NUM_LEVELS] = '{default: '0};
   logic [LVL_W-1:0]      cpu_level [NUM_CPUS] = '{default: NO_LEVEL};

   map_request_type       queued_requests [$];
   map_answer_type        awaited_answers [$];
   map_request_type       offered_request;
   int                    sender_idle_pct = 11;
   int                    receiver_idle_pct = 68;
   int                    hold_requests = 0;
   int                    holds_started = 0;
   int                    hold_left = 0;
   int                    mismatch_count = 0;
   int                    cycle_count = 0;

   cpu_priority_map_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_cpu_index      (req_cpu_index),
      .req_priority_req   (req_priority_req),
      .req_affinity_mask  (req_affinity_mask),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found          (rsp_found),
      .rsp_candidate_mask (rsp_candidate_mask),
      .rsp_found_level    (rsp_found_level),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic logic [LVL_W-1:0] level_for(logic [PRIO_W-1:0] prio);
      int                lv;
      logic [LVL_W-1:0]  result;
      if (prio == idle_prio_cfg) begin
         return '0;
      end
      if (prio == invalid_prio_cfg) begin
         return NO_LEVEL;
      end
      if (prio > max_rt_cfg) begin
         lv = 1;
      end else begin
         lv = int'(max_rt_cfg) - int'(prio) + 2;
      end
      if (lv > LEVEL_TOP) begin
         lv = LEVEL_TOP;
      end
      result = lv[LVL_W-1:0];
      return result;
   endfunction

   function automatic map_answer_type map_request(map_request_type r);
      map_answer_type       ans;
      logic [LVL_W-1:0]     lv;
      logic [LVL_W-1:0]     old;
      logic [NUM_CPUS-1:0]  hit;
      int                   i;
      ans = '0;
      lv = level_for(r.prio);
      if (r.kind == REQ_SET) begin
         old = cpu_level[r.cpu];
         if (old != lv) begin
            if (lv != NO_LEVEL) begin
               level_mask[lv[LEVEL_W-1:0]][r.cpu] = 1'b1;
            end
            if (old != NO_LEVEL) begin
               level_mask[old[LEVEL_W-1:0]][r.cpu] = 1'b0;
            end
            cpu_level[r.cpu] = lv;
         end
      end else if (lv != NO_LEVEL) begin
         for (i = 0; i < int'(lv) && i < NUM_LEVELS && !ans.found; i++) begin
            hit = level_mask[i] & r.affinity;
            if (hit != '0) begin
               ans.found = 1'b1;
               ans.candidates = hit;
               ans.level = i[LEVEL_W-1:0];
            end
         end
      end
      return ans;
   endfunction

   function automatic map_request_type random_request();
      map_request_type r;
      int              pick;
      r.kind = ($urandom_range(1) == 1) ? REQ_FIND : REQ_SET;
      r.cpu = CPU_W'($urandom_range(NUM_CPUS - 1));
      pick = $urandom_range(99);
      if (pick < 15) begin
         r.prio = idle_prio_cfg;
      end else if (pick < 25) begin
         r.prio = invalid_prio_cfg;
      end else if (pick < 70) begin
         r.prio = PRIO_W'($urandom_range(int'(max_rt_cfg)));
      end else begin
         r.prio = PRIO_W'($urandom_range(255));
      end
      pick = $urandom_range(99);
      if (pick < 10) begin
         r.affinity = '0;
      end else if (pick < 20) begin
         r.affinity = '1;
      end else if (pick < 45) begin
         r.affinity = NUM_CPUS'(1) << $urandom_range(NUM_CPUS - 1);
      end else if (pick < 60) begin
         r.affinity = (NUM_CPUS'(1) << $urandom_range(NUM_CPUS - 1))
                    | (NUM_CPUS'(1) << $urandom_range(NUM_CPUS - 1));
      end else begin
         r.affinity = $urandom;
      end
      return r;
   endfunction

   task automatic queue_request(req_kind_type kind, int cpu, int prio, logic [31:0] affinity);
      map_request_type r;
      r.kind = kind;
      r.cpu = CPU_W'(cpu);
      r.prio = PRIO_W'(prio);
      r.affinity = affinity;
      queued_requests.push_back(r);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      unique case (idx)
         CSR_IDLE_PRIO: begin
            idle_prio_cfg = value;
         end
         CSR_INVALID_PRIO: begin
            invalid_prio_cfg = value;
         end
         CSR_MAX_RT_PRIO: begin
            max_rt_cfg = value[MAXRT_W-1:0];
         end
         default: begin
         end
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic wait_for_drain();
      do begin
         @(negedge clock);
      end while (queued_requests.size() != 0 || req_valid || awaited_answers.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("cycle %0d: %s", cycle_count, what);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin : drive
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            awaited_answers.push_back(map_request(offered_request));
            next_valid = 1'b0;
         end
         if (!next_valid && queued_requests.size() != 0
             && $urandom_range(99) >= sender_idle_pct) begin
            offered_request = queued_requests.pop_front();
            req_type <= offered_request.kind;
            req_cpu_index <= offered_request.cpu;
            req_priority_req <= offered_request.prio;
            req_affinity_mask <= offered_request.affinity;
            next_valid = 1'b1;
         end
         req_valid <= next_valid;
      end
   end

   always @(posedge clock) begin : hold_timer
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_started != hold_requests) begin
         holds_started <= holds_started + 1;
         hold_left <= LONG_HOLD;
      end
   end

   always @(posedge clock) begin : receive
      map_answer_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_answers.size() == 0) begin
               note_mismatch($sformatf("unexpected beat: found %0b mask %h level %0d",
                                       rsp_found, rsp_candidate_mask, rsp_found_level));
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_found !== want.found || rsp_candidate_mask !== want.candidates
                   || rsp_found_level !== want.level) begin
                  note_mismatch($sformatf(
                     "expected found %0b mask %h level %0d, got found %0b mask %h level %0d",
                     want.found, want.candidates, want.level,
                     rsp_found, rsp_candidate_mask, rsp_found_level));
               end
            end
         end
         if (hold_left > 0 || holds_started != hold_requests) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   initial begin : stimulus
      int a;
      int b;
      int c;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      queue_request(REQ_FIND, 0, 0, 32'hFFFF_FFFF);
      queue_request(REQ_SET, 0, 255, 32'h0);
      queue_request(REQ_SET, 31, 0, 32'hFFFF_FFFF);
      queue_request(REQ_SET, 31, 0, 32'h0);
      queue_request(REQ_SET, 5, 100, 32'h0);
      queue_request(REQ_SET, 7, 47, 32'h0);
      queue_request(REQ_SET, 9, 254, 32'h0);
      queue_request(REQ_FIND, 0, 0, 32'hFFFF_FFFF);
      queue_request(REQ_FIND, 0, 0, 32'hFFFF_FFFE);
      queue_request(REQ_FIND, 0, 255, 32'hFFFF_FFFF);
      queue_request(REQ_FIND, 0, 254, 32'hFFFF_FFFF);
      queue_request(REQ_FIND, 0, 46, 32'h0000_0080);
      queue_request(REQ_FIND, 0, 47, 32'h0000_0080);
      queue_request(REQ_FIND, 0, 0, 32'h8000_0000);
      queue_request(REQ_FIND, 0, 50, 32'hFFFF_FFFF);
      queue_request(REQ_SET, 0, 254, 32'h0);
      queue_request(REQ_FIND, 31, 0, 32'h0);
      queue_request(REQ_SET, 31, 200, 32'h0);
      queue_request(REQ_FIND, 0, 0, 32'h8000_0000);
      queue_request(REQ_SET, 5, 254, 32'hFFFF_FFFF);
      queue_request(REQ_FIND, 0, 1, 32'hFFFF_FFFF);
      wait_for_drain();
      for (int g = 0; g < 6; g++) begin
         unique case (g)
            0: begin
               a = 0;   b = 255; c = 61;
            end
            1: begin
               a = 200; b = 200; c = 0;
            end
            2: begin
               a = 255; b = 0;   c = 61;
            end
            4: begin
               a = 0;   b = 0;   c = 0;
            end
            default: begin
               a = $urandom_range(255);
               b = $urandom_range(255);
               c = $urandom_range(61);
            end
         endcase
         write_csr(CSR_IDLE_PRIO, CSR_DATA_W'(a));
         write_csr(CSR_INVALID_PRIO, CSR_DATA_W'(b));
         write_csr(CSR_MAX_RT_PRIO, CSR_DATA_W'(c));
         @(negedge clock);
         sender_idle_pct = (g < 2) ? 11 : (g < 4) ? 68 : 0;
         receiver_idle_pct = (g < 2) ? 68 : (g < 4) ? 11 : 0;
         for (int n = 0; n < GROUP_ITEMS; n++) begin
            queued_requests.push_back(random_request());
         end
         if (g == 1) begin
            hold_requests = hold_requests + 1;
         end
         wait_for_drain();
      end
      if (mismatch_count == 0 && awaited_answers.size() == 0) begin
         $display("Verification passed");
      end else begin
         if (awaited_answers.size() != 0) begin
            $display("%0d expected beats never arrived", awaited_answers.size());
         end
         $display("Verification failed");
      end
      $finish;
   end

endmodule
